### rtl/core/dlaq_pkg.sv
// ----------------------------------------------------------------------------
// dlaq_pkg
// Shared constants, codes and cell interface types for the alarm queue.
// ----------------------------------------------------------------------------
package dlaq_pkg;

	localparam int NUM_ALARMS = 32;
	localparam int ID_W       = $clog2(NUM_ALARMS);
	localparam int DLY_W      = 32;
	localparam int AID_W      = 8;

	localparam int S_FIELDS_W = AID_W + DLY_W + DLY_W + 1;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = AID_W + 2 + DLY_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [DLY_W-1:0] NO_TIMER = '1;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_REMOVE    = 2'd1,
		OP_POP_FIRST = 2'd2,
		OP_POP_LAST  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ERROR = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TMR_NONE   = 2'd0,
		TMR_ARM    = 2'd1,
		TMR_DISARM = 2'd2
	} timer_cmd_t;

	typedef enum logic [2:0] {
		CM_HOLD      = 3'd0,
		CM_START     = 3'd1,
		CM_WALK_INS  = 3'd2,
		CM_WALK_REM  = 3'd3,
		CM_POP_FIRST = 3'd4,
		CM_POP_LAST  = 3'd5
	} cell_mode_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		cell_mode_t       mode;
		logic [ID_W-1:0]  id;
		logic [DLY_W-1:0] key;
		logic             refresh;
		logic [DLY_W-1:0] refresh_val;
	} cell_cmd_t;

	// What a cell shows to its neighbors.
	typedef struct packed {
		logic             vld;
		logic [ID_W-1:0]  id;
		logic [DLY_W-1:0] dly;
		logic             tok;
		logic [DLY_W-1:0] wkey;
		logic             fwd;
		logic [DLY_W-1:0] fwd_key;
	} cell_view_t;

	// What a cell reports to the controller.
	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] tail_id;
	} cell_stat_t;

endpackage

### rtl/core/delta_list_alarm_queue.sv
// ----------------------------------------------------------------------------
// delta_list_alarm_queue
// Pending alarm queue kept as a sorted row of cells holding relative delays.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one operation item (insert, remove, pop first,
//   pop last); the master channel returns one result item per operation with
//   a status, the popped id and a timer command with its value.
//   Cell position k holds the k-th queued alarm and its delay relative to the
//   alarm in front of it. Insert and remove send a token down the row, one
//   cell per cycle, until it finds the insertion point or the matching id;
//   the splice then happens as all cells shift by one together.
//   Errors and pops go from decode straight to the result state; an insert
//   or remove first walks the token, so its time grows with the position
//   where the token stops, and a remove also passes through the finish state.
//   One item is in work at a time; s_tready is high in the cycle after the
//   result is loaded into the output register, so a new item can be taken
//   while that result still waits. A stalled receiver holds the result, and
//   the next result waits in the sequencer until the register frees.
//   Reset empties the queue at once and clears the output register.
// ----------------------------------------------------------------------------
module delta_list_alarm_queue import dlaq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // alarm_id, delay_ms, time_to_interrupt, registered
	input  logic [1:0]          s_tuser,  // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // id_out, timer_cmd, timer_value
	output logic [1:0]          m_tuser   // status
);

	cell_cmd_t  cmd;
	logic       commit;
	cell_view_t views  [NUM_ALARMS];
	cell_view_t lefts  [NUM_ALARMS];
	cell_view_t rights [NUM_ALARMS];
	cell_stat_t stats  [NUM_ALARMS];

	// Neighbor wiring; the ends of the row see an empty position.
	always_comb begin
		for (int i = 0; i < NUM_ALARMS; i++) begin
			lefts[i]  = (i == 0) ? '0 : views[(i == 0) ? 0 : i - 1];
			rights[i] = (i == NUM_ALARMS - 1) ? '0 :
			            views[(i == NUM_ALARMS - 1) ? i : i + 1];
		end
	end

	dlaq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.commit   (commit),
		.head     (views[0]),
		.stats    (stats)
	);

	for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_cell
		dlaq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.is_head (g == 0),
			.cmd     (cmd),
			.commit  (commit),
			.left    (lefts[g]),
			.right   (rights[g]),
			.view    (views[g]),
			.stat    (stats[g])
		);
	end

endmodule

### rtl/core/dlaq_cell.sv
// ----------------------------------------------------------------------------
// dlaq_cell
// One list position: holds an alarm id and its relative delay, carries the
// search token and shifts entries to or from its neighbors.
// ----------------------------------------------------------------------------
module dlaq_cell import dlaq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       is_head,
	input  cell_cmd_t  cmd,
	input  logic       commit,
	input  cell_view_t left,
	input  cell_view_t right,
	output cell_view_t view,
	output cell_stat_t stat
);

	logic             vld_q, tok_q, pas_q;
	logic [ID_W-1:0]  id_q;
	logic [DLY_W-1:0] dly_q, wkey_q;

	logic             vld_d, tok_d, pas_d;
	logic [ID_W-1:0]  id_d;
	logic [DLY_W-1:0] dly_d, wkey_d;

	logic le, match, pass, hit;

	always_comb begin
		le    = vld_q && (dly_q <= wkey_q);
		match = vld_q && (id_q == cmd.id);
		pass  = 1'b0;
		hit   = 1'b0;
		if (cmd.mode == CM_WALK_INS) begin
			pass = tok_q && le;
			hit  = tok_q && !le;
		end else if (cmd.mode == CM_WALK_REM) begin
			pass = tok_q && !match;
			hit  = tok_q && match;
		end
	end

	assign view.vld     = vld_q;
	assign view.id      = id_q;
	assign view.dly     = dly_q;
	assign view.tok     = tok_q;
	assign view.wkey    = wkey_q;
	assign view.fwd     = pass;
	assign view.fwd_key = wkey_q - dly_q;

	assign stat.hit     = hit;
	assign stat.tail_id = (vld_q && !right.vld) ? id_q : '0;

	always_comb begin
		vld_d  = vld_q;
		tok_d  = tok_q;
		pas_d  = pas_q;
		id_d   = id_q;
		dly_d  = dly_q;
		wkey_d = wkey_q;
		unique case (cmd.mode)
			CM_START: begin
				tok_d  = is_head;
				pas_d  = 1'b0;
				wkey_d = cmd.key;
				if (is_head && cmd.refresh && vld_q) begin
					dly_d = cmd.refresh_val;
				end
			end
			CM_WALK_INS: begin
				if (commit) begin
					tok_d = 1'b0;
					pas_d = 1'b0;
					// Cells ahead of the token keep their entries; the token cell
					// takes the new alarm and everything behind it moves back one.
					if (!pas_q) begin
						if (tok_q) begin
							vld_d = 1'b1;
							id_d  = cmd.id;
							dly_d = wkey_q;
						end else begin
							vld_d = left.vld;
							id_d  = left.id;
							dly_d = left.tok ? (left.dly - left.wkey) : left.dly;
						end
					end
				end else begin
					if (pass) begin
						tok_d = 1'b0;
						pas_d = 1'b1;
					end
					if (left.fwd) begin
						tok_d  = 1'b1;
						wkey_d = left.fwd_key;
					end
				end
			end
			CM_WALK_REM: begin
				if (commit) begin
					tok_d = 1'b0;
					pas_d = 1'b0;
					// The matched entry folds its delay into the successor as the
					// rest of the list moves forward one.
					if (!pas_q) begin
						vld_d = right.vld;
						id_d  = right.id;
						dly_d = tok_q ? (right.dly + dly_q) : right.dly;
					end
				end else begin
					if (pass) begin
						tok_d = 1'b0;
						pas_d = 1'b1;
					end
					if (left.fwd) begin
						tok_d  = 1'b1;
						wkey_d = left.fwd_key;
					end
				end
			end
			CM_POP_FIRST: begin
				vld_d = right.vld;
				id_d  = right.id;
				dly_d = right.dly;
			end
			CM_POP_LAST: begin
				if (vld_q && !right.vld) begin
					vld_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_q <= 1'b0;
			pas_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
			tok_q <= tok_d;
			pas_q <= pas_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= id_d;
		dly_q  <= dly_d;
		wkey_q <= wkey_d;
	end

endmodule

### rtl/core/dlaq_ctrl.sv
// ----------------------------------------------------------------------------
// dlaq_ctrl
// Sequencer: takes one item, checks it, drives the cell row and builds the
// result item in an output register.
// ----------------------------------------------------------------------------
module dlaq_ctrl import dlaq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [1:0]          m_tuser,
	output cell_cmd_t           cmd,
	output logic                commit,
	input  cell_view_t          head,
	input  cell_stat_t          stats [NUM_ALARMS]
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_FINISH,
		S_RESULT
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [AID_W-1:0]    aid_q;
	logic [DLY_W-1:0]    key_q, tti_q;
	logic                reg_q;
	logic [NUM_ALARMS-1:0] inq_q;
	logic                was_first_q;
	status_t             res_status_q;
	logic [AID_W-1:0]    res_id_q;
	timer_cmd_t          res_cmd_q;
	logic [DLY_W-1:0]    res_val_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic            hit_any;
	logic [ID_W-1:0] tail_id;
	logic [ID_W-1:0] aid_ix;
	logic            id_bad, queued, empty, ins_ok, rem_ok;

	always_comb begin
		hit_any = 1'b0;
		tail_id = '0;
		for (int i = 0; i < NUM_ALARMS; i++) begin
			hit_any = hit_any | stats[i].hit;
			tail_id = tail_id | stats[i].tail_id;
		end
	end

	assign aid_ix = aid_q[ID_W-1:0];
	assign id_bad = {24'd0, aid_q} >= 32'(NUM_ALARMS);
	assign queued = inq_q[aid_ix];
	assign empty  = !head.vld;
	assign ins_ok = !id_bad && !queued;
	assign rem_ok = !id_bad && reg_q && queued;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign commit = (state_q == S_WALK) && hit_any;

	always_comb begin
		cmd             = '0;
		cmd.mode        = CM_HOLD;
		cmd.id          = aid_ix;
		cmd.key         = key_q;
		cmd.refresh_val = tti_q;
		unique case (state_q)
			S_DECODE: begin
				unique case (op_q)
					OP_INSERT: begin
						if (ins_ok) begin
							cmd.mode    = CM_START;
							cmd.refresh = (tti_q != NO_TIMER);
						end
					end
					OP_REMOVE: begin
						if (rem_ok) begin
							cmd.mode        = CM_START;
							cmd.refresh     = 1'b1;
							cmd.refresh_val = (tti_q != NO_TIMER) ? tti_q : '0;
						end
					end
					OP_POP_FIRST: if (!empty) cmd.mode = CM_POP_FIRST;
					OP_POP_LAST:  if (!empty) cmd.mode = CM_POP_LAST;
				endcase
			end
			S_WALK: begin
				cmd.mode = (op_q == OP_INSERT) ? CM_WALK_INS : CM_WALK_REM;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_INSERT;
			aid_q        <= '0;
			key_q        <= '0;
			tti_q        <= '0;
			reg_q        <= 1'b0;
			inq_q        <= '0;
			was_first_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_id_q     <= '0;
			res_cmd_q    <= TMR_NONE;
			res_val_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			// In the result state the output register is handled below.
			if (m_tvalid_q && m_tready && (state_q != S_RESULT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= op_t'(s_tuser);
						aid_q   <= s_tdata[AID_W-1:0];
						key_q   <= s_tdata[AID_W+DLY_W-1:AID_W];
						tti_q   <= s_tdata[AID_W+2*DLY_W-1:AID_W+DLY_W];
						reg_q   <= s_tdata[AID_W+2*DLY_W];
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_cmd_q <= TMR_NONE;
					res_val_q <= '0;
					unique case (op_q)
						OP_INSERT: begin
							res_id_q <= '0;
							if (ins_ok) begin
								res_status_q <= ST_OK;
								state_q      <= S_WALK;
							end else begin
								res_status_q <= ST_ERROR;
								state_q      <= S_RESULT;
							end
						end
						OP_REMOVE: begin
							res_id_q <= '0;
							if (rem_ok) begin
								res_status_q <= ST_OK;
								state_q      <= S_WALK;
							end else begin
								res_status_q <= ST_ERROR;
								state_q      <= S_RESULT;
							end
						end
						OP_POP_FIRST: begin
							state_q <= S_RESULT;
							if (empty) begin
								res_status_q <= ST_EMPTY;
								res_id_q     <= '0;
							end else begin
								res_status_q   <= ST_OK;
								res_id_q       <= AID_W'(head.id);
								inq_q[head.id] <= 1'b0;
							end
						end
						OP_POP_LAST: begin
							state_q <= S_RESULT;
							if (empty) begin
								res_status_q <= ST_EMPTY;
								res_id_q     <= '0;
							end else begin
								res_status_q   <= ST_OK;
								res_id_q       <= AID_W'(tail_id);
								inq_q[tail_id] <= 1'b0;
							end
						end
					endcase
				end
				S_WALK: begin
					if (hit_any) begin
						if (op_q == OP_INSERT) begin
							inq_q[aid_ix] <= 1'b1;
							// A new alarm at the front reprograms the timer.
							if (head.tok) begin
								res_cmd_q <= TMR_ARM;
								res_val_q <= head.wkey;
							end
							state_q <= S_RESULT;
						end else begin
							inq_q[aid_ix] <= 1'b0;
							was_first_q   <= head.tok;
							state_q       <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (!head.vld) begin
						res_cmd_q <= TMR_DISARM;
					end else if (was_first_q && (head.dly != '0)) begin
						res_cmd_q <= TMR_ARM;
						res_val_q <= head.dly;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_DATA_W'({res_val_q, res_cmd_q, res_id_q});
						m_tuser_q  <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/dlaq_checker.sv
// ----------------------------------------------------------------------------
// dlaq_checker
// Port-level checks on the alarm queue, bound to the top level.
// ----------------------------------------------------------------------------
module dlaq_checker import dlaq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	localparam int CMD_LO = AID_W;
	localparam int VAL_LO = AID_W + 2;

	// A stalled result must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	// A timer value is only reported with an arm command.
	a_val_arm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[CMD_LO+1:CMD_LO] != TMR_ARM) |->
		m_tdata[VAL_LO+DLY_W-1:VAL_LO] == '0)
		else $error("timer value without arm command");

	// Failed or empty operations never touch the timer.
	a_err_timer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata[CMD_LO+1:CMD_LO] == TMR_NONE)
		else $error("timer command on a failed item");

	// Timer commands come from insert or remove, which report no popped id.
	a_cmd_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[CMD_LO+1:CMD_LO] != TMR_NONE) |-> m_tdata[AID_W-1:0] == '0)
		else $error("popped id reported with a timer command");

endmodule

bind delta_list_alarm_queue dlaq_checker u_checker (.*);
